FILE: hdl/cpsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIDR port set match package
// Sizes, request and status codes, and the command and status groups that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cpsm_pkg;

   localparam int MAX_ENTRIES      = 64;
   localparam int RANGES_PER_ENTRY = 8;

   localparam int ADDR_W   = 128;
   localparam int HALF_W   = 64;
   localparam int PREFIX_W = 8;
   localparam int PORT_W   = 16;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 2;

   localparam int ENTRY_AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COUNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int LANE_W   = (RANGES_PER_ENTRY > 1) ? $clog2(RANGES_PER_ENTRY) : 1;
   localparam int RANGE_W  = $clog2(RANGES_PER_ENTRY + 1);

   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd2;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NO_ENTRY   = 2'd3;

   typedef struct packed {
      logic latch;
      logic exec;
      logic issue;
      logic load_rsp;
   } cpsm_cmd_type;

   typedef struct packed {
      logic is_lookup;
      logic walk_more;
   } cpsm_stat_type;

   // Leading prefix bits set; a prefix above the address width sets all bits.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] plen);
      logic [ADDR_W-1:0] m;
      for (int i = 0; i < ADDR_W; i++) begin
         m[ADDR_W-1-i] = (PREFIX_W'(i) < plen);
      end
      return m;
   endfunction

endpackage

FILE: hdl/cpsm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIDR port set match channels
// Request and response channels with valid, ready and payload.
// ----------------------------------------------------------------------------
interface cpsm_req_if;
   import cpsm_pkg::*;

   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [HALF_W-1:0]   addr_hi;
   logic [HALF_W-1:0]   addr_lo;
   logic [PREFIX_W-1:0] prefix_len;
   logic                negate;
   logic [PORT_W-1:0]   port_lo;
   logic [PORT_W-1:0]   port_hi;
   logic [PORT_W-1:0]   lookup_port;

   modport source (output valid, output req_type, output addr_hi, output addr_lo,
                   output prefix_len, output negate, output port_lo, output port_hi,
                   output lookup_port, input ready);
   modport sink (input valid, input req_type, input addr_hi, input addr_lo,
                 input prefix_len, input negate, input port_lo, input port_hi,
                 input lookup_port, output ready);
endinterface

interface cpsm_rsp_if;
   import cpsm_pkg::*;

   logic                valid;
   logic                ready;
   logic                contained;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output contained, output status, input ready);
   modport sink (input valid, input contained, input status, output ready);
endinterface

FILE: hdl/cidr_port_set_match_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIDR port set match
// Table of address blocks with port ranges and a set membership lookup.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one response. A clear, add
// or append request passes from the idle state through execute to the
// response state; a lookup also passes through the entry walk, which reads
// one entry per cycle from the entry memory and compares all of its port
// ranges side by side. The response state waits until the output register is
// free. A finished response waits in the output register while the next
// request is accepted and worked on. No clearing pass follows reset: only
// entries below the entry count and ranges below their count are ever
// examined.
module cidr_port_set_match_top (
   input logic        clock,
   input logic        reset,
   cpsm_req_if.sink   req_if,
   cpsm_rsp_if.source rsp_if
);
   import cpsm_pkg::*;

   cpsm_cmd_type  cmd;
   cpsm_stat_type stat;

   cpsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cpsm_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_req_type    (req_if.req_type),
      .in_addr_hi     (req_if.addr_hi),
      .in_addr_lo     (req_if.addr_lo),
      .in_prefix_len  (req_if.prefix_len),
      .in_negate      (req_if.negate),
      .in_port_lo     (req_if.port_lo),
      .in_port_hi     (req_if.port_hi),
      .in_lookup_port (req_if.lookup_port),
      .out_contained  (rsp_if.contained),
      .out_status     (rsp_if.status)
   );

   // The walk never reads past the stored entries.
   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> stat.walk_more)
      else $error("entry read issued beyond the entry count");

   // A response is loaded only when the output register is free.
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_if.valid || rsp_if.ready))
      else $error("response overwritten before it was taken");

   // An accepted request is executed in the next cycle and blocks new ones.
   a_latch_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |=> (cmd.exec && !req_if.ready))
      else $error("accepted request not executed in the following cycle");

   // The request register is loaded exactly on an accepted request.
   a_latch_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.latch == (req_if.valid && req_if.ready))
      else $error("request capture out of step with the handshake");

endmodule

FILE: hdl/cpsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIDR port set match controller
// Sequences request capture, execution, the entry walk and the response.
// ----------------------------------------------------------------------------
module cpsm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  cpsm_pkg::cpsm_stat_type stat,
   output cpsm_pkg::cpsm_cmd_type  cmd
);
   import cpsm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.is_lookup ? S_WALK : S_RESP;
         end
         S_WALK: begin
            cmd.issue = stat.walk_more;
            if (!stat.walk_more) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/cpsm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CIDR port set match datapath
// Request registers, entry and range memories, match logic and result.
// ----------------------------------------------------------------------------
module cpsm_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  cpsm_pkg::cpsm_cmd_type            cmd,
   output cpsm_pkg::cpsm_stat_type           stat,
   input  logic [cpsm_pkg::REQ_W-1:0]        in_req_type,
   input  logic [cpsm_pkg::HALF_W-1:0]       in_addr_hi,
   input  logic [cpsm_pkg::HALF_W-1:0]       in_addr_lo,
   input  logic [cpsm_pkg::PREFIX_W-1:0]     in_prefix_len,
   input  logic                              in_negate,
   input  logic [cpsm_pkg::PORT_W-1:0]       in_port_lo,
   input  logic [cpsm_pkg::PORT_W-1:0]       in_port_hi,
   input  logic [cpsm_pkg::PORT_W-1:0]       in_lookup_port,
   output logic                              out_contained,
   output logic [cpsm_pkg::STATUS_W-1:0]     out_status
);
   import cpsm_pkg::*;

   logic [REQ_W-1:0]    rq_type_ff;
   logic [HALF_W-1:0]   rq_hi_ff;
   logic [HALF_W-1:0]   rq_lo_ff;
   logic [PREFIX_W-1:0] rq_pfx_ff;
   logic                rq_neg_ff;
   logic [PORT_W-1:0]   rq_plo_ff;
   logic [PORT_W-1:0]   rq_phi_ff;
   logic [PORT_W-1:0]   rq_port_ff;

   logic [COUNT_W-1:0]  entry_count_ff, entry_count_in;
   logic [RANGE_W-1:0]  newest_count_ff, newest_count_in;
   logic [STATUS_W-1:0] op_status_ff, op_status_in;
   logic [COUNT_W-1:0]  idx_ff;
   logic                rd_vld_ff;
   logic                pos_hit_ff, neg_hit_ff;
   logic                contained_ff;
   logic [STATUS_W-1:0] status_ff;

   logic [HALF_W-1:0]   ent_hi_mem  [MAX_ENTRIES];
   logic [HALF_W-1:0]   ent_lo_mem  [MAX_ENTRIES];
   logic [PREFIX_W-1:0] ent_pfx_mem [MAX_ENTRIES];
   logic                ent_neg_mem [MAX_ENTRIES];
   logic [RANGE_W-1:0]  ent_cnt_mem [MAX_ENTRIES];

   logic [HALF_W-1:0]   rd_hi_ff;
   logic [HALF_W-1:0]   rd_lo_ff;
   logic [PREFIX_W-1:0] rd_pfx_ff;
   logic                rd_neg_ff;
   logic [RANGE_W-1:0]  rd_cnt_ff;
   logic [PORT_W-1:0]   rd_rlo [RANGES_PER_ENTRY];
   logic [PORT_W-1:0]   rd_rhi [RANGES_PER_ENTRY];

   logic [ADDR_W-1:0]   new_mask;
   logic [ADDR_W-1:0]   rd_mask;
   logic [ENTRY_AW-1:0] last_entry;
   logic [ENTRY_AW-1:0] wr_addr;
   logic [ENTRY_AW-1:0] rd_addr;
   logic [LANE_W-1:0]   wr_lane;
   logic [RANGE_W-1:0]  wr_cnt;
   logic                add_ok, app_ok;
   logic                ent_we, lane_we;
   logic                addr_hit;
   logic [RANGES_PER_ENTRY-1:0] lane_hit;
   logic                entry_hit;

   assign new_mask   = prefix_mask(rq_pfx_ff);
   assign last_entry = ENTRY_AW'(entry_count_ff - COUNT_W'(1));
   assign add_ok     = (rq_type_ff == REQ_ADD) && (entry_count_ff != COUNT_W'(MAX_ENTRIES));
   assign app_ok     = (rq_type_ff == REQ_APPEND) && (entry_count_ff != '0)
                       && (newest_count_ff != RANGE_W'(RANGES_PER_ENTRY));
   assign ent_we     = cmd.exec && add_ok;
   assign lane_we    = cmd.exec && (add_ok || app_ok);
   assign wr_addr    = add_ok ? entry_count_ff[ENTRY_AW-1:0] : last_entry;
   assign wr_lane    = add_ok ? '0 : newest_count_ff[LANE_W-1:0];
   assign wr_cnt     = add_ok ? RANGE_W'(1) : newest_count_ff + RANGE_W'(1);
   assign rd_addr    = idx_ff[ENTRY_AW-1:0];

   assign stat.is_lookup = (rq_type_ff == REQ_LOOKUP);
   assign stat.walk_more = (idx_ff < entry_count_ff);

   always_comb begin
      entry_count_in  = entry_count_ff;
      newest_count_in = newest_count_ff;
      op_status_in    = STAT_OK;
      case (rq_type_ff)
         REQ_CLEAR: begin
            entry_count_in = '0;
         end
         REQ_ADD: begin
            if (add_ok) begin
               entry_count_in  = entry_count_ff + COUNT_W'(1);
               newest_count_in = RANGE_W'(1);
            end else begin
               op_status_in = STAT_TABLE_FULL;
            end
         end
         REQ_APPEND: begin
            if (entry_count_ff == '0) begin
               op_status_in = STAT_NO_ENTRY;
            end else if (!app_ok) begin
               op_status_in = STAT_RANGE_FULL;
            end else begin
               newest_count_in = wr_cnt;
            end
         end
         default: begin
            op_status_in = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rq_type_ff <= in_req_type;
         rq_hi_ff   <= in_addr_hi;
         rq_lo_ff   <= in_addr_lo;
         rq_pfx_ff  <= in_prefix_len;
         rq_neg_ff  <= in_negate;
         rq_plo_ff  <= in_port_lo;
         rq_phi_ff  <= in_port_hi;
         rq_port_ff <= in_lookup_port;
      end
      if (cmd.exec) begin
         newest_count_ff <= newest_count_in;
         op_status_ff    <= op_status_in;
      end
      if (cmd.load_rsp) begin
         contained_ff <= stat.is_lookup && pos_hit_ff && !neg_hit_ff;
         status_ff    <= op_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         idx_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         pos_hit_ff     <= 1'b0;
         neg_hit_ff     <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         if (cmd.exec) begin
            entry_count_ff <= entry_count_in;
            idx_ff         <= '0;
            pos_hit_ff     <= 1'b0;
            neg_hit_ff     <= 1'b0;
         end else begin
            if (cmd.issue) begin
               idx_ff <= idx_ff + COUNT_W'(1);
            end
            if (rd_vld_ff && entry_hit) begin
               if (rd_neg_ff) begin
                  neg_hit_ff <= 1'b1;
               end else begin
                  pos_hit_ff <= 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_hi_mem[wr_addr]  <= rq_hi_ff & new_mask[ADDR_W-1:HALF_W];
         ent_lo_mem[wr_addr]  <= rq_lo_ff & new_mask[HALF_W-1:0];
         ent_pfx_mem[wr_addr] <= rq_pfx_ff;
         ent_neg_mem[wr_addr] <= rq_neg_ff;
      end
      if (lane_we) begin
         ent_cnt_mem[wr_addr] <= wr_cnt;
      end
      if (cmd.issue) begin
         rd_hi_ff  <= ent_hi_mem[rd_addr];
         rd_lo_ff  <= ent_lo_mem[rd_addr];
         rd_pfx_ff <= ent_pfx_mem[rd_addr];
         rd_neg_ff <= ent_neg_mem[rd_addr];
         rd_cnt_ff <= ent_cnt_mem[rd_addr];
      end
   end

   for (genvar l = 0; l < RANGES_PER_ENTRY; l++) begin : g_lane
      logic [PORT_W-1:0] lane_lo_mem [MAX_ENTRIES];
      logic [PORT_W-1:0] lane_hi_mem [MAX_ENTRIES];

      always_ff @(posedge clock) begin
         if (lane_we && (wr_lane == LANE_W'(l))) begin
            lane_lo_mem[wr_addr] <= rq_plo_ff;
            lane_hi_mem[wr_addr] <= rq_phi_ff;
         end
         if (cmd.issue) begin
            rd_rlo[l] <= lane_lo_mem[rd_addr];
            rd_rhi[l] <= lane_hi_mem[rd_addr];
         end
      end

      assign lane_hit[l] = (RANGE_W'(l) < rd_cnt_ff)
                           && ((rd_rhi[l] == '0)
                               || ((rq_port_ff >= rd_rlo[l]) && (rq_port_ff <= rd_rhi[l])));
   end

   assign rd_mask   = prefix_mask(rd_pfx_ff);
   assign addr_hit  = ((rq_hi_ff & rd_mask[ADDR_W-1:HALF_W]) == rd_hi_ff)
                      && ((rq_lo_ff & rd_mask[HALF_W-1:0]) == rd_lo_ff);
   assign entry_hit = addr_hit && (|lane_hit);

   assign out_contained = contained_ff;
   assign out_status    = status_ff;

endmodule
